[hdl/hvr_pkg.sv]
// Package for the haversine waypoint reach block.
// Fixed-point constants, cell word types and the CORDIC angle table function.
`timescale 1ns / 1ps
package hvr_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int MAX_STAGES = 40;
  localparam int NSTG = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  localparam int SQ_STEPS = 31;
  localparam int LAT = 4 + NSTG + 4 + SQ_STEPS + NSTG + 3;

  localparam int AW = 36;

  localparam logic signed [AW-1:0] INV_GAIN = 36'sd652032874;
  localparam logic signed [AW-1:0] HALF_PI = 36'sd1686629713;
  localparam logic signed [AW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [67:0] RADK = 68'sd2012227627;
  localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
  localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
  localparam logic [35:0] DIST_MAX = 36'd20106193000;
  localparam logic [31:0] QUARTER_PI = 32'd843314857;

  localparam logic [0:0] REG_TOL = 1'b0;
  localparam logic [0:0] REG_RADIUS = 1'b1;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [61:0] opnd;
    logic [32:0] rem;
    logic [30:0] root;
  } sq_t;

  function automatic logic [31:0] atan_q30(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int k;
    sum = 64'd0;
    if (i == 0) begin
      return QUARTER_PI;
    end
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return 32'((sum + 64'h8000_0000) >> 32);
  endfunction

  // round half away from zero, then shift
  function automatic logic signed [67:0] rnd(input logic signed [67:0] v, input int s);
    logic signed [67:0] t;
    t = v + (68'sd1 <<< (s - 1));
    if (v[67]) begin
      t = t - 68'sd1;
    end
    return t >>> s;
  endfunction

  function automatic logic signed [33:0] wrap_turn(input logic signed [33:0] d);
    logic signed [33:0] r;
    r = d;
    if (d >= HALF_TURN) begin
      r = d - FULL_TURN;
    end else if (d < -HALF_TURN) begin
      r = d + FULL_TURN;
    end
    return r;
  endfunction

endpackage

[hdl/hvr_in_if.sv]
// Input channel: position pair word with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps
interface hvr_in_if;
  logic valid;
  logic ready;
  logic signed [30:0] cur_lat;
  logic signed [31:0] cur_lon;
  logic signed [30:0] target_lat;
  logic signed [31:0] target_lon;
  modport source(output valid, cur_lat, cur_lon, target_lat, target_lon, input ready);
  modport sink(input valid, cur_lat, cur_lon, target_lat, target_lon, output ready);
endinterface

[hdl/hvr_out_if.sv]
// Output channel: distance word with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps
interface hvr_out_if;
  logic valid;
  logic ready;
  logic [34:0] distance_mm;
  logic reached;
  modport source(output valid, distance_mm, reached, input ready);
  modport sink(input valid, distance_mm, reached, output ready);
endinterface

[hdl/hvr_cordic_cell.sv]
// One CORDIC micro-rotation cell, rotation or vectoring mode.
// Depends on hvr_pkg.
`timescale 1ns / 1ps
module hvr_cordic_cell (
  input  logic clk,
  input  logic en,
  input  logic vec,
  input  logic [5:0] shift,
  input  logic signed [hvr_pkg::AW-1:0] angle,
  input  hvr_pkg::cordic_t d,
  output hvr_pkg::cordic_t q
);
  import hvr_pkg::*;

  logic signed [AW-1:0] dx;
  logic signed [AW-1:0] dy;
  logic pos;

  always_comb begin
    dx = d.y >>> shift;
    dy = d.x >>> shift;
    pos = vec ? d.y[AW-1] : !d.z[AW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pos) begin
        q.x <= d.x - dx;
        q.y <= d.y + dy;
        q.z <= d.z - angle;
      end else begin
        q.x <= d.x + dx;
        q.y <= d.y - dy;
        q.z <= d.z + angle;
      end
    end
  end
endmodule

[hdl/hvr_sqrt_cell.sv]
// One restoring square-root cell: consumes two operand bits, yields one root bit.
// Depends on hvr_pkg.
`timescale 1ns / 1ps
module hvr_sqrt_cell (
  input  logic clk,
  input  logic en,
  input  hvr_pkg::sq_t d,
  output hvr_pkg::sq_t q
);
  import hvr_pkg::*;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic take;

  always_comb begin
    rem_sh = {d.rem, d.opnd[61:60]};
    trial = {2'b00, d.root, 2'b01};
    take = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.opnd <= {d.opnd[59:0], 2'b00};
      q.rem <= take ? 33'(rem_sh - trial) : rem_sh[32:0];
      q.root <= {d.root[29:0], take};
    end
  end
endmodule

[hdl/haversine_waypoint_reach.sv]
// Haversine great-circle distance and waypoint reach flag, fully pipelined.
// Depends on hvr_pkg, hvr_in_if, hvr_out_if, hvr_cordic_cell, hvr_sqrt_cell.
`timescale 1ns / 1ps
// Takes one position pair per cycle and returns one distance word per pair, in order.
// The pipe depth is set by the two rows of CORDIC cells and the 31-cell square-root rows.
// A stall on the output holds the whole
// pipe. Write configuration only while no word is in flight.
module haversine_waypoint_reach (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wen,
  input  logic [0:0] cfg_index,
  input  logic [26:0] cfg_data,
  hvr_in_if.sink pos,
  hvr_out_if.source res
);
  import hvr_pkg::*;

  logic en;
  logic [LAT-1:0] vpipe;
  logic [26:0] tolerance_mm;
  logic [22:0] earth_radius_m;

  assign en = !res.valid || res.ready;
  assign pos.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_mm <= 27'd1000;
      earth_radius_m <= 23'd6371000;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_TOL: tolerance_mm <= cfg_data;
        REG_RADIUS: earth_radius_m <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      res.valid <= 1'b0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], pos.valid};
      res.valid <= vpipe[LAT-1];
    end
  end

  // S1: differences with wrap
  logic signed [33:0] d_lat, d_lon;
  logic signed [30:0] r_clat, r_tlat;
  always_ff @(posedge clk) begin
    if (en) begin
      d_lat <= wrap_turn(34'(pos.target_lat) - 34'(pos.cur_lat));
      d_lon <= wrap_turn(34'(pos.target_lon) - 34'(pos.cur_lon));
      r_clat <= pos.cur_lat;
      r_tlat <= pos.target_lat;
    end
  end

  // S2: scale to radians
  logic signed [67:0] p_hlat, p_hlon, p_c1, p_c2;
  always_ff @(posedge clk) begin
    if (en) begin
      p_hlat <= 68'(d_lat) * RADK;
      p_hlon <= 68'(d_lon) * RADK;
      p_c1 <= 68'(r_clat) * RADK;
      p_c2 <= 68'(r_tlat) * RADK;
    end
  end

  // S3: round to Q30
  logic signed [AW-1:0] hlat, hlon, t1, t2;
  always_ff @(posedge clk) begin
    if (en) begin
      hlat <= AW'(rnd(p_hlat, 31));
      hlon <= AW'(rnd(p_hlon, 31));
      t1 <= AW'(rnd(p_c1, 30));
      t2 <= AW'(rnd(p_c2, 30));
    end
  end

  // S4: chain entry, cosine fold
  logic signed [AW-1:0] m1, m2;
  cordic_t r_in [4];
  logic n1_s4, n2_s4;
  always_comb begin
    m1 = t1[AW-1] ? -t1 : t1;
    m2 = t2[AW-1] ? -t2 : t2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r_in[0] <= '{x: INV_GAIN, y: '0, z: hlat};
      r_in[1] <= '{x: INV_GAIN, y: '0, z: hlon};
      r_in[2] <= '{x: INV_GAIN, y: '0, z: (m1 > HALF_PI) ? PI_Q30 - m1 : m1};
      r_in[3] <= '{x: INV_GAIN, y: '0, z: (m2 > HALF_PI) ? PI_Q30 - m2 : m2};
      n1_s4 <= m1 > HALF_PI;
      n2_s4 <= m2 > HALF_PI;
    end
  end

  cordic_t rot [4][NSTG];
  logic [NSTG-1:0] n1_d, n2_d;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_d <= {n1_d[NSTG-2:0], n1_s4};
      n2_d <= {n2_d[NSTG-2:0], n2_s4};
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_rot
    for (genvar g = 0; g < NSTG; g++) begin : g_cell
      localparam logic [31:0] ANG = atan_q30(g);
      hvr_cordic_cell u_cell (
        .clk  (clk),
        .en   (en),
        .vec  (1'b0),
        .shift(6'(g)),
        .angle(AW'(ANG)),
        .d    ((g == 0) ? r_in[c] : rot[c][(g == 0) ? 0 : g - 1]),
        .q    (rot[c][g])
      );
    end
  end

  // S5: squares and cosine product
  logic signed [32:0] s_lat, s_lon, c1, c2;
  logic signed [65:0] p_sl, p_so, p_cc;
  always_comb begin
    s_lat = 33'(rot[0][NSTG-1].y);
    s_lon = 33'(rot[1][NSTG-1].y);
    c1 = n1_d[NSTG-1] ? -33'(rot[2][NSTG-1].x) : 33'(rot[2][NSTG-1].x);
    c2 = n2_d[NSTG-1] ? -33'(rot[3][NSTG-1].x) : 33'(rot[3][NSTG-1].x);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_sl <= 66'(s_lat) * 66'(s_lat);
      p_so <= 66'(s_lon) * 66'(s_lon);
      p_cc <= 66'(c1) * 66'(c2);
    end
  end

  // S6: round
  logic signed [33:0] sdl2, sdo2, cc;
  always_ff @(posedge clk) begin
    if (en) begin
      sdl2 <= 34'(rnd(68'(p_sl), 30));
      sdo2 <= 34'(rnd(68'(p_so), 30));
      cc <= 34'(rnd(68'(p_cc), 30));
    end
  end

  // S7: weighted longitude term
  logic signed [67:0] p_a;
  logic signed [33:0] sdl2_d;
  always_ff @(posedge clk) begin
    if (en) begin
      p_a <= 68'(cc) * 68'(sdo2);
      sdl2_d <= sdl2;
    end
  end

  // S8: a with clamp
  logic signed [35:0] a_sum;
  logic [30:0] a_c;
  sq_t sqa_in, sqb_in;
  always_comb begin
    a_sum = 36'(sdl2_d) + 36'(rnd(p_a, 30));
    if (a_sum < 0) begin
      a_c = '0;
    end else if (a_sum > 36'(Q30_ONE)) begin
      a_c = 31'(Q30_ONE);
    end else begin
      a_c = a_sum[30:0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqa_in <= '{opnd: {1'b0, a_c, 30'd0}, rem: '0, root: '0};
      sqb_in <= '{opnd: {1'b0, 31'(31'(Q30_ONE) - a_c), 30'd0}, rem: '0, root: '0};
    end
  end

  sq_t sqa [SQ_STEPS];
  sq_t sqb [SQ_STEPS];
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    hvr_sqrt_cell u_sa (
      .clk(clk), .en(en),
      .d  ((g == 0) ? sqa_in : sqa[(g == 0) ? 0 : g - 1]),
      .q  (sqa[g])
    );
    hvr_sqrt_cell u_sb (
      .clk(clk), .en(en),
      .d  ((g == 0) ? sqb_in : sqb[(g == 0) ? 0 : g - 1]),
      .q  (sqb[g])
    );
  end

  cordic_t v_in;
  cordic_t vec [NSTG];
  assign v_in = '{x: AW'(sqb[SQ_STEPS-1].root), y: AW'(sqa[SQ_STEPS-1].root), z: '0};

  for (genvar g = 0; g < NSTG; g++) begin : g_vec
    localparam logic [31:0] ANG = atan_q30(g);
    hvr_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .vec  (1'b1),
      .shift(6'(g)),
      .angle(AW'(ANG)),
      .d    ((g == 0) ? v_in : vec[(g == 0) ? 0 : g - 1]),
      .q    (vec[g])
    );
  end

  // S9: central angle
  logic signed [AW-1:0] zv;
  logic [31:0] theta;
  assign zv = vec[NSTG-1].z;
  always_ff @(posedge clk) begin
    if (en) begin
      if (zv < 0) begin
        theta <= '0;
      end else if (zv > HALF_PI) begin
        theta <= {HALF_PI[30:0], 1'b0};
      end else begin
        theta <= {zv[30:0], 1'b0};
      end
    end
  end

  // S10: scale by radius
  logic [54:0] prod;
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 55'(earth_radius_m) * 55'(theta);
    end
  end

  // S11: to millimetres with rounding
  logic [35:0] dist_raw;
  logic [39:0] lo_x;
  assign lo_x = 40'(prod[29:0]) * 40'd1000 + 40'h2000_0000;
  always_ff @(posedge clk) begin
    if (en) begin
      dist_raw <= 36'(prod[54:30]) * 36'd1000 + 36'(lo_x[39:30]);
    end
  end

  // output word
  logic [35:0] dist_s;
  assign dist_s = (dist_raw > DIST_MAX) ? DIST_MAX : dist_raw;
  always_ff @(posedge clk) begin
    if (en) begin
      res.distance_mm <= dist_s[34:0];
      res.reached <= dist_s < 36'(tolerance_mm);
    end
  end
endmodule
